// ----- rtl/ssmap_pkg.sv -----
// Shared types, register codes and byte classification helpers for the
// substring search block. Depends on nothing; used by all but ssmap_outq.
package ssmap_pkg;

	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;
	localparam int LEN_W  = 5;

	typedef enum logic [2:0] {
		REG_QUERY_LO = 3'd0,
		REG_QUERY_HI = 3'd1,
		REG_QUERY_LEN = 3'd2,
		REG_MATCH_CASE = 3'd3,
		REG_WHOLE_WORD = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [63:0]      query_lo;
		logic [63:0]      query_hi;
		logic [LEN_W-1:0] query_len;
		logic             match_case;
		logic             whole_word;
	} cfg_t;

	function automatic logic [7:0] fold(input logic [7:0] c, input logic en);
		logic [7:0] r;
		r = c;
		if (en && (c inside {[8'h41:8'h5A]})) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], 8'h5F});
	endfunction

endpackage

// ----- rtl/ssmap_cfg.sv -----
// APB-style configuration registers for the substring search block.
// Depends on ssmap_pkg for the register codes and the cfg_t bundle.
module ssmap_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ssmap_pkg::ADDR_W-1:0]  paddr,
	input  logic [ssmap_pkg::DATA_W-1:0]  pwdata,
	output logic [ssmap_pkg::DATA_W-1:0]  prdata,
	output logic                          pready,
	output ssmap_pkg::cfg_t               cfg
);

	ssmap_pkg::cfg_t     cfg_q;
	ssmap_pkg::reg_idx_t idx;
	logic                wr_en;

	assign pready = 1'b1;
	assign idx    = ssmap_pkg::reg_idx_t'(paddr[ssmap_pkg::ADDR_W-1:3]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.query_lo   <= '0;
			cfg_q.query_hi   <= '0;
			cfg_q.query_len  <= '0;
			cfg_q.match_case <= 1'b1;
			cfg_q.whole_word <= 1'b0;
		end else if (wr_en) begin
			case (idx)
				ssmap_pkg::REG_QUERY_LO:   cfg_q.query_lo   <= pwdata;
				ssmap_pkg::REG_QUERY_HI:   cfg_q.query_hi   <= pwdata;
				ssmap_pkg::REG_QUERY_LEN:  cfg_q.query_len  <= pwdata[ssmap_pkg::LEN_W-1:0];
				ssmap_pkg::REG_MATCH_CASE: cfg_q.match_case <= pwdata[0];
				ssmap_pkg::REG_WHOLE_WORD: cfg_q.whole_word <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			ssmap_pkg::REG_QUERY_LO:   prdata = cfg_q.query_lo;
			ssmap_pkg::REG_QUERY_HI:   prdata = cfg_q.query_hi;
			ssmap_pkg::REG_QUERY_LEN:  prdata = ssmap_pkg::DATA_W'(cfg_q.query_len);
			ssmap_pkg::REG_MATCH_CASE: prdata = ssmap_pkg::DATA_W'(cfg_q.match_case);
			ssmap_pkg::REG_WHOLE_WORD: prdata = ssmap_pkg::DATA_W'(cfg_q.whole_word);
			default: prdata = '0;
		endcase
	end

endmodule

// ----- rtl/ssmap_outq.sv -----
// Four-entry result queue: takes up to two results per cycle, delivers one
// unless stalled. Generic over the result width; no package dependency.
module ssmap_outq #(
	parameter int W = 52
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_a,
	input  logic         push_b,
	input  logic [W-1:0] din_a,
	input  logic [W-1:0] din_b,
	output logic         room,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [W-1:0] out_data
);

	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [PW:0]   cnt_q;
	logic          pop;
	logic [PW:0]   n_push;

	assign out_valid = (cnt_q != '0);
	assign out_data  = mem_q[rp_q];
	assign room      = (cnt_q <= (PW+1)'(DEPTH - 2));
	assign pop       = out_valid && !out_stall;
	assign n_push    = (PW+1)'(push_a) + (PW+1)'(push_b);

	always_ff @(posedge clk) begin
		if (push_a) begin
			mem_q[wp_q] <= din_a;
		end
		if (push_b) begin
			mem_q[wp_q + PW'(1)] <= din_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + n_push[PW-1:0];
			if (pop) begin
				rp_q <= rp_q + PW'(1);
			end
			cnt_q <= cnt_q + n_push - (PW+1)'(pop);
		end
	end

endmodule

// ----- rtl/ssmap_core.sv -----
// Input register, byte window, parallel query compare and per-text state.
// Depends on ssmap_pkg; feeds up to two packed results per byte to ssmap_outq.
module ssmap_core #(
	parameter int MAX_QUERY_BYTES = 16,
	parameter int POSITION_BITS   = 24,
	parameter int RW              = 2 * POSITION_BITS + 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ssmap_pkg::cfg_t cfg,
	input  logic            text_valid,
	output logic            text_stall,
	input  logic [7:0]      text_byte,
	input  logic            final_byte,
	input  logic            room,
	output logic            push_a,
	output logic            push_b,
	output logic [RW-1:0]   res_a,
	output logic [RW-1:0]   res_b
);

	localparam int MAXQ = MAX_QUERY_BYTES;
	localparam int PB   = POSITION_BITS;
	localparam int FW   = $clog2(MAXQ + 2);
	localparam int LIW  = (MAXQ > 1) ? $clog2(MAXQ + 1) : 1;
	localparam int LW   = ssmap_pkg::LEN_W;
	localparam logic [PB-1:0] POS_MAX   = {PB{1'b1}};
	localparam logic [PB:0]   TOTAL_MAX = {1'b1, {PB{1'b0}}};

	typedef struct packed {
		logic [PB-1:0] pos;
		logic          found;
		logic [PB:0]   total;
		logic          ovf;
		logic          eot;
	} res_t;

	logic          v_s1;
	logic [7:0]    byte_s1;
	logic          fin_s1;
	logic          accept;
	logic          fire;

	logic [7:0]    win_q [MAXQ];
	logic [FW-1:0] fill_q;
	logic [PB-1:0] idx_q;
	logic          ovf_q;
	logic          pend_q;
	logic [PB-1:0] pend_pos_q;
	logic [PB:0]   cnt_q;

	logic [7:0]    wn [MAXQ+1];
	logic [7:0]    wf [MAXQ+1];
	logic [7:0]    qf [MAXQ];
	logic          hit_len [MAXQ+1];
	logic          fold_en;
	logic [FW-1:0] fill_n;
	logic [LW-1:0] fill_ext;
	logic [LW-1:0] len;
	logic [LIW-1:0] len_idx;
	logic          len_ok;
	logic          hit;
	logic          reject;
	logic          match_ok;
	logic          pend_emit;
	logic          m_emit;
	logic          m_pend;
	logic [PB-1:0] start;
	logic [PB-1:0] idx_n;
	logic          ovf_n;
	logic [PB:0]   cnt1;
	logic [PB:0]   cnt2;
	res_t          r_pend;
	res_t          r_match;
	res_t          r_bare;
	res_t          r_a;

	assign text_stall = v_s1 && !room;
	assign accept     = text_valid && !text_stall;
	assign fire       = v_s1 && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept || (v_s1 && !room);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= text_byte;
			fin_s1  <= final_byte;
		end
	end

	assign fold_en = !cfg.match_case;
	assign wn[0]   = byte_s1;
	assign wf[0]   = ssmap_pkg::fold(wn[0], fold_en);

	for (genvar i = 1; i <= MAXQ; i++) begin : g_win
		assign wn[i] = win_q[i-1];
		assign wf[i] = ssmap_pkg::fold(wn[i], fold_en);
	end

	for (genvar j = 0; j < MAXQ; j++) begin : g_query
		if (j < 8) begin : g_lo
			assign qf[j] = ssmap_pkg::fold(cfg.query_lo[8*j +: 8], fold_en);
		end else begin : g_hi
			assign qf[j] = ssmap_pkg::fold(cfg.query_hi[8*(j-8) +: 8], fold_en);
		end
	end

	assign hit_len[0] = 1'b0;
	for (genvar l = 1; l <= MAXQ; l++) begin : g_len
		logic [l-1:0] eq;
		for (genvar j = 0; j < l; j++) begin : g_cmp
			assign eq[j] = (wf[l-1-j] == qf[j]);
		end
		assign hit_len[l] = &eq;
	end

	assign fill_n   = (fill_q == FW'(MAXQ + 1)) ? fill_q : fill_q + FW'(1);
	assign fill_ext = LW'(fill_n);
	assign len      = cfg.query_len;
	assign len_idx  = len[LIW-1:0];
	assign len_ok   = (len != '0) && (len <= LW'(MAXQ)) && (fill_ext >= len);
	assign hit      = len_ok && hit_len[len_idx];
	assign reject   = cfg.whole_word && (fill_ext > len) && ssmap_pkg::is_word(wn[len_idx]);
	assign match_ok = hit && !reject;
	assign m_emit   = match_ok && (!cfg.whole_word || fin_s1);
	assign m_pend   = match_ok && cfg.whole_word && !fin_s1;
	assign start    = idx_q - PB'(len) + PB'(1);

	assign pend_emit = pend_q && !ssmap_pkg::is_word(byte_s1);

	assign idx_n = (!ovf_q && (idx_q != POS_MAX)) ? idx_q + PB'(1) : idx_q;
	assign ovf_n = ovf_q || (idx_q == POS_MAX);

	assign cnt1 = (pend_emit && (cnt_q != TOTAL_MAX)) ? cnt_q + (PB+1)'(1) : cnt_q;
	assign cnt2 = (m_emit && (cnt1 != TOTAL_MAX)) ? cnt1 + (PB+1)'(1) : cnt1;

	always_comb begin
		r_pend.pos    = pend_pos_q;
		r_pend.found  = 1'b1;
		r_pend.total  = cnt1;
		r_pend.ovf    = ovf_q;
		r_pend.eot    = fin_s1 && !m_emit;

		r_match.pos   = start;
		r_match.found = 1'b1;
		r_match.total = cnt2;
		r_match.ovf   = ovf_n;
		r_match.eot   = fin_s1;

		r_bare.pos    = '0;
		r_bare.found  = 1'b0;
		r_bare.total  = cnt_q;
		r_bare.ovf    = ovf_n;
		r_bare.eot    = 1'b1;

		if (pend_emit) begin
			r_a = r_pend;
		end else if (m_emit) begin
			r_a = r_match;
		end else begin
			r_a = r_bare;
		end
	end

	assign push_a = fire && (pend_emit || m_emit || fin_s1);
	assign push_b = fire && pend_emit && m_emit;
	assign res_a  = r_a;
	assign res_b  = r_match;

	always_ff @(posedge clk) begin
		if (fire) begin
			for (int i = 0; i < MAXQ; i++) begin
				win_q[i] <= wn[i];
			end
			if (m_pend) begin
				pend_pos_q <= start;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			idx_q  <= '0;
			ovf_q  <= 1'b0;
			pend_q <= 1'b0;
			cnt_q  <= '0;
		end else if (fire) begin
			if (fin_s1) begin
				fill_q <= '0;
				idx_q  <= '0;
				ovf_q  <= 1'b0;
				pend_q <= 1'b0;
				cnt_q  <= '0;
			end else begin
				fill_q <= fill_n;
				idx_q  <= idx_n;
				ovf_q  <= ovf_n;
				pend_q <= m_pend;
				cnt_q  <= cnt2;
			end
		end
	end

endmodule

// ----- rtl/substring_match_all_positions_top.sv -----
// Streaming substring search: finds every start position of a query in a byte stream.
// Top level; instantiates ssmap_cfg, ssmap_core and ssmap_outq; uses ssmap_pkg.
//
// Usage:
//  - Program the query, its length, case folding and whole-word mode through the
//    APB port (64-bit registers at byte addresses 0, 8, 16, 24, 32) while idle.
//  - Text bytes enter on text_valid/text_stall, one transfer per byte, with
//    final_byte on the last byte of a text.
//  - Results leave on match_valid/match_stall. Each byte yields zero, one or two
//    results; the final byte always yields at least one, tagged end_of_text.
//  - A result is formed from the registered byte and then offered from the queue.
//  - Throughput: one byte per cycle while each byte yields at most one result
//    and match_stall is low; a byte that yields two results fills two entries
//    of the four-entry result queue; the input holds at fewer than two free slots.
//  - A whole-word match is confirmed on the byte after it, or at once on the
//    final byte.
//  - When match_stall is high, results wait in the queue and text_stall rises
//    once it has fewer than two free slots.
//  - Reset clears the registers to their defaults and drops all per-text state.
module substring_match_all_positions_top #(
	parameter int MAX_QUERY_BYTES = 16,
	parameter int POSITION_BITS   = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ssmap_pkg::ADDR_W-1:0]  paddr,
	input  logic [ssmap_pkg::DATA_W-1:0]  pwdata,
	output logic [ssmap_pkg::DATA_W-1:0]  prdata,
	output logic                          pready,
	input  logic                          text_valid,
	output logic                          text_stall,
	input  logic [7:0]                    text_byte,
	input  logic                          final_byte,
	output logic                          match_valid,
	input  logic                          match_stall,
	output logic [POSITION_BITS-1:0]      match_position,
	output logic                          match_found,
	output logic [POSITION_BITS:0]        match_total,
	output logic                          position_overflow,
	output logic                          end_of_text
);

	localparam int PB = POSITION_BITS;

	typedef struct packed {
		logic [PB-1:0] pos;
		logic          found;
		logic [PB:0]   total;
		logic          ovf;
		logic          eot;
	} res_t;

	localparam int RW = $bits(res_t);

	ssmap_pkg::cfg_t cfg;
	logic            room;
	logic            push_a;
	logic            push_b;
	logic [RW-1:0]   res_a;
	logic [RW-1:0]   res_b;
	logic [RW-1:0]   out_data;
	res_t            res;

	ssmap_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ssmap_core #(
		.MAX_QUERY_BYTES (MAX_QUERY_BYTES),
		.POSITION_BITS   (POSITION_BITS),
		.RW              (RW)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text_byte  (text_byte),
		.final_byte (final_byte),
		.room       (room),
		.push_a     (push_a),
		.push_b     (push_b),
		.res_a      (res_a),
		.res_b      (res_b)
	);

	ssmap_outq #(
		.W (RW)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_a    (push_a),
		.push_b    (push_b),
		.din_a     (res_a),
		.din_b     (res_b),
		.room      (room),
		.out_valid (match_valid),
		.out_stall (match_stall),
		.out_data  (out_data)
	);

	assign res               = out_data;
	assign match_position    = res.pos;
	assign match_found       = res.found;
	assign match_total       = res.total;
	assign position_overflow = res.ovf;
	assign end_of_text       = res.eot;

endmodule
